@@ src/mplru_pkg.sv @@
// Shared types and constants for the memory-pressure LRU victim selector.
package mplru_pkg;

	localparam int SLOTS = 16;
	localparam int SLOT_W = 4;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PCT_W = 7;
	localparam int KB_W = 32;
	localparam int PROD_W = KB_W + 7;

	localparam logic [1:0] OP_TOUCH = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FOREGROUND = 2'd2;
	localparam logic [1:0] OP_PRESSURE = 2'd3;

	localparam logic [2:0] LVL_NONE = 3'd0;
	localparam logic [2:0] LVL_WARNING = 3'd1;
	localparam logic [2:0] LVL_MODERATE = 3'd2;
	localparam logic [2:0] LVL_CRITICAL = 3'd3;
	localparam logic [2:0] LVL_TOTAL_ZERO = 3'd4;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_NOTIFY = 2'd1;
	localparam logic [1:0] ACT_KILL = 2'd2;

	localparam logic [1:0] REG_CRITICAL = 2'd0;
	localparam logic [1:0] REG_MODERATE = 2'd1;
	localparam logic [1:0] REG_WARNING = 2'd2;

	// Per-cycle command from the sequencer to every cell of the chain.
	typedef struct packed {
		logic shift;        // cells at or past the mark take their right neighbor's slot
		logic append;       // the cell at the tail position loads the new slot
		logic [SLOT_W-1:0] new_slot;
	} mplru_chain_cmd_t;

endpackage

@@ src/memory_pressure_lru_victim_select_core.sv @@
// Top level of the memory-pressure LRU victim selector: chain of recency cells and sequencer.
// An item is taken when start is high and busy low; busy then stays high until the cycle in
// which its single result appears for one cycle on the strobe, which the receiver cannot
// stall, and the next item may be taken at the end of that same cycle. Touch and foreground
// items search the chain of cells, close the gap, append, and register the result; a remove
// skips the append. A pressure item first runs the one-bit-per-cycle divider, which takes 39
// quotient steps, and then grades the quotient. When no victim is sought, the result is then
// registered. Otherwise the chain is scanned one cell per cycle, first for a suspended victim
// and then for any unprotected one; a victim that is found has its gap closed before the
// result is registered. A total of zero goes straight to registering the result.
module memory_pressure_lru_victim_select_core
	import mplru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic [SLOT_W-1:0]   app_slot,
	input  logic [KB_W-1:0]     free_kb,
	input  logic [KB_W-1:0]     mem_kb,
	input  logic [SLOTS-1:0]    suspended_mask,
	output logic                result_valid,
	output logic [2:0]          pressure_level,
	output logic                victim_valid,
	output logic [SLOT_W-1:0]   victim_slot,
	output logic [1:0]          kill_action,
	output logic                status
);

	localparam int POS_W = $clog2(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_FIND, ST_CLOSE, ST_APPEND, ST_DIV, ST_SCAN, ST_DONE
	} state_t;

	state_t state_q;
	logic [PCT_W-1:0] crit_q, mod_q, warn_q;
	logic [1:0]       op_q;
	logic [SLOT_W-1:0] key_q;
	logic [SLOTS-1:0] susp_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] fg_slot_q;
	logic             fg_valid_q;
	logic [POS_W-1:0] mark_q;
	logic             found_q;
	logic [CNT_W-1:0] scan_q;
	logic             pass_q;
	logic             res_valid_q;
	logic [2:0]       level_q;
	logic             vic_valid_q;
	logic [SLOT_W-1:0] vic_q;
	logic [1:0]       act_q;
	logic             status_q;

	mplru_chain_cmd_t cmd;
	logic [SLOT_W-1:0] cell_slot [SLOTS];
	logic [SLOTS-1:0]  cell_hit;
	logic [SLOTS-1:0]  hit_live;
	logic              div_go, div_done;
	logic [PROD_W-1:0] quot;
	logic              apb_wr;
	logic [SLOT_W-1:0] scan_slot;
	logic              scan_ok;
	logic [POS_W-1:0]  hit_pos;
	logic              hit_any;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_CRITICAL: prdata[PCT_W-1:0] = crit_q;
			REG_MODERATE: prdata[PCT_W-1:0] = mod_q;
			REG_WARNING:  prdata[PCT_W-1:0] = warn_q;
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q <= PCT_W'(10);
			mod_q <= PCT_W'(15);
			warn_q <= PCT_W'(25);
		end else if (apb_wr) begin
			unique case (paddr[3:2])
				REG_CRITICAL: crit_q <= pwdata[PCT_W-1:0];
				REG_MODERATE: mod_q <= pwdata[PCT_W-1:0];
				REG_WARNING:  warn_q <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		mplru_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.at_tail    (count_q == CNT_W'(i)),
			.past_mark  (POS_W'(i) >= mark_q),
			.right_slot (cell_slot[(i + 1) % SLOTS]),
			.key        (key_q),
			.slot       (cell_slot[i]),
			.hit        (cell_hit[i])
		);
		assign hit_live[i] = cell_hit[i] && (CNT_W'(i) < count_q);
	end

	// Slots are unique in the order, so at most one live cell matches.
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit_live[i]) begin
				hit_pos = POS_W'(i);
			end
		end
	end
	assign hit_any = |hit_live;

	assign scan_slot = cell_slot[scan_q[POS_W-1:0]];
	assign scan_ok = !(fg_valid_q && fg_slot_q == scan_slot) &&
		(pass_q || susp_q[scan_slot]);

	mplru_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.avail  (free_kb),
		.total  (mem_kb),
		.done   (div_done),
		.quot   (quot)
	);

	assign div_go = (state_q == ST_IDLE) && start && opcode == OP_PRESSURE && mem_kb != '0;

	always_comb begin
		cmd = '0;
		cmd.new_slot = key_q;
		cmd.shift = (state_q == ST_CLOSE) && found_q;
		cmd.append = (state_q == ST_APPEND) && (found_q || count_q < CNT_W'(SLOTS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			fg_slot_q <= '0;
			fg_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
			found_q <= 1'b0;
			pass_q <= 1'b0;
			scan_q <= '0;
			mark_q <= '0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= opcode;
						key_q <= app_slot;
						susp_q <= suspended_mask;
						level_q <= LVL_NONE;
						vic_valid_q <= 1'b0;
						vic_q <= '0;
						act_q <= ACT_NONE;
						status_q <= 1'b0;
						if (opcode != OP_PRESSURE) begin
							state_q <= ST_FIND;
						end else if (mem_kb == '0) begin
							level_q <= LVL_TOTAL_ZERO;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_FIND: begin
					found_q <= hit_any;
					mark_q <= hit_pos;
					if (op_q == OP_FOREGROUND) begin
						fg_slot_q <= key_q;
						fg_valid_q <= 1'b1;
					end else if (op_q == OP_REMOVE && fg_valid_q && fg_slot_q == key_q) begin
						fg_slot_q <= '0;
						fg_valid_q <= 1'b0;
					end
					state_q <= ST_CLOSE;
				end
				ST_CLOSE: begin
					if (found_q) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= (op_q == OP_REMOVE) ? ST_DONE : ST_APPEND;
				end
				ST_APPEND: begin
					if (cmd.append) begin
						count_q <= count_q + 1'b1;
					end else begin
						status_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DIV: begin
					if (div_done) begin
						scan_q <= '0;
						pass_q <= 1'b0;
						if (quot < PROD_W'(crit_q)) begin
							level_q <= LVL_CRITICAL;
							state_q <= ST_SCAN;
						end else if (quot < PROD_W'(mod_q)) begin
							level_q <= LVL_MODERATE;
							state_q <= ST_SCAN;
						end else begin
							if (quot < PROD_W'(warn_q)) begin
								level_q <= LVL_WARNING;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q >= count_q) begin
						if (pass_q) begin
							state_q <= ST_DONE;
						end else begin
							pass_q <= 1'b1;
							scan_q <= '0;
						end
					end else if (scan_ok) begin
						vic_valid_q <= 1'b1;
						vic_q <= scan_slot;
						act_q <= (level_q == LVL_CRITICAL) ? ACT_KILL : ACT_NOTIFY;
						mark_q <= scan_q[POS_W-1:0];
						found_q <= 1'b1;
						op_q <= OP_REMOVE;
						state_q <= ST_CLOSE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DONE: begin
					res_valid_q <= 1'b1;
					found_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign pressure_level = level_q;
	assign victim_valid = vic_valid_q;
	assign victim_slot = vic_q;
	assign kill_action = act_q;
	assign status = status_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("entry count beyond table size");
	a_result_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while still busy");
	a_victim_action: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && victim_valid |-> kill_action != ACT_NONE)
		else $error("victim reported without kill action");
	a_status_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> pressure_level == LVL_NONE && !victim_valid)
		else $error("full status on a pressure item");
`endif

endmodule

@@ src/mplru_cell.sv @@
// One recency cell: holds a slot, flags a match and closes gaps by taking its neighbor's slot.
module mplru_cell
	import mplru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  mplru_chain_cmd_t      cmd,
	input  logic                  at_tail,
	input  logic                  past_mark,
	input  logic [SLOT_W-1:0]     right_slot,
	input  logic [SLOT_W-1:0]     key,
	output logic [SLOT_W-1:0]     slot,
	output logic                  hit
);

	logic [SLOT_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.append && at_tail) begin
			slot_q <= cmd.new_slot;
		end else if (cmd.shift && past_mark) begin
			slot_q <= right_slot;
		end
	end

	assign slot = slot_q;
	assign hit = (slot_q == key);

endmodule

@@ src/mplru_div.sv @@
// Restoring divider that forms avail*100/total one quotient bit per cycle.
module mplru_div
	import mplru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [KB_W-1:0]     avail,
	input  logic [KB_W-1:0]     total,
	output logic                done,
	output logic [PROD_W-1:0]   quot
);

	localparam int STEP_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] num_q;
	logic [PROD_W-1:0] quot_q;
	logic [KB_W:0]     rem_q;
	logic [KB_W-1:0]   den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [KB_W:0]     trial;
	logic [KB_W:0]     diff;

	assign trial = {rem_q[KB_W-1:0], num_q[PROD_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(PROD_W);
				// avail*100 = avail*64 + avail*32 + avail*4
				num_q <= ({7'd0, avail} << 6) + ({7'd0, avail} << 5) + ({7'd0, avail} << 2);
				den_q <= total;
				rem_q <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[PROD_W-2:0], 1'b0};
				if (!diff[KB_W]) begin
					rem_q <= diff;
					quot_q <= {quot_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quot_q <= {quot_q[PROD_W-2:0], 1'b0};
				end
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
